// ===== rtl/core/wcas_pkg.sv =====
// Shared types, constants and the cosine table function for the windowed cosine atom unit.
`timescale 1ns / 1ps

package wcas_pkg;

    localparam int SAMPLE_BITS         = 16;
    localparam int FRAC_BITS           = SAMPLE_BITS - 1;
    localparam int LENGTH_BITS         = 16;
    localparam int PHASE_BITS_DEF      = 32;
    localparam int COS_TABLE_DEPTH_DEF = 1024;
    localparam int QUEUE_DEPTH         = 4;

    localparam longint COS_COEF [7] = '{
        64'd1073741824, 64'd1324675879, 64'd272375560, 64'd22401992,
        64'd987048, 64'd27060, 64'd506
    };

    localparam longint unsigned ENTRY_MAX = (64'd1 << FRAC_BITS) - 64'd1;

    typedef struct packed {
        logic [FRAC_BITS-1:0]          window_sample;
        logic                          atom_start;
        logic signed [SAMPLE_BITS-1:0] amplitude;
        logic [LENGTH_BITS-1:0]        atom_length;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          clipped;
    } out_item_t;

    function automatic logic [FRAC_BITS-1:0] cos_entry(input int idx, input int addr_bits);
        longint unsigned u;
        longint unsigned v;
        longint unsigned e;
        longint          r;
        longint          t;
        u = longint'(2 * idx + 1) << (29 - addr_bits);
        v = (u * u) >> 30;
        r = COS_COEF[6];
        for (int k = 5; k >= 0; k--)
        begin
            t = $signed(($unsigned(r) * v) >> 30);
            r = COS_COEF[k] - t;
            if (r < 0)
            begin
                r = 0;
            end
        end
        e = ($unsigned(r) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        if (e > ENTRY_MAX)
        begin
            e = ENTRY_MAX;
        end
        return FRAC_BITS'(e);
    endfunction

endpackage

// ===== rtl/core/wcas_front.sv =====
// Front end: accepts items, holds phase and amplitude, computes the atom start phase.
`timescale 1ns / 1ps

module wcas_front #(
    parameter int PHASE_BITS = wcas_pkg::PHASE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [PHASE_BITS-1:0]           cfg_wr_data,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  wcas_pkg::in_item_t              item,
    output logic                            push_valid,
    input  logic                            push_ready,
    output logic [PHASE_BITS-1:0]           push_phase,
    output logic [wcas_pkg::FRAC_BITS-1:0]  push_window,
    output logic [wcas_pkg::SAMPLE_BITS-1:0] push_amplitude
);

    localparam int S   = wcas_pkg::FRAC_BITS;
    localparam int SB  = wcas_pkg::SAMPLE_BITS;
    localparam int L   = wcas_pkg::LENGTH_BITS;
    localparam int H   = (PHASE_BITS + 1) / 2;
    localparam int PW2 = PHASE_BITS + 2;
    localparam int PLW = H + L + 1;
    localparam int PHW = PHASE_BITS - H + L + 1;
    localparam logic [L:0] LEN_BIAS = (L + 1)'(2);
    localparam logic [PHASE_BITS-1:0] QUARTER = PHASE_BITS'(1) << (PHASE_BITS - 2);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_ADD,
        ST_PUSH
    } state_t;

    state_t                state_reg;
    logic [PHASE_BITS-1:0] phase_step_reg;
    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [SB-1:0]         held_amp_reg;
    logic [S-1:0]          win_reg;
    logic [L:0]            len2_reg;
    logic [PLW-1:0]        prod_lo_reg;
    logic [PHW-1:0]        prod_hi_reg;
    logic [PHASE_BITS-1:0] start_phase_reg;

    logic                  accept;
    logic                  push;
    logic [PW2-1:0]        prod_sum;

    assign item_ready = (state_reg == ST_IDLE) && push_ready;
    assign accept     = item_valid && item_ready;
    assign push_valid = (state_reg == ST_IDLE) ? (item_valid && !item.atom_start)
                                               : (state_reg == ST_PUSH);
    assign push       = push_valid && push_ready;

    assign push_phase     = (state_reg == ST_IDLE) ? phase_acc_reg : start_phase_reg;
    assign push_window    = (state_reg == ST_IDLE) ? item.window_sample : win_reg;
    assign push_amplitude = held_amp_reg;

    assign prod_sum = PW2'(prod_lo_reg) + (PW2'(prod_hi_reg) << H);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_step_reg <= '0;
            phase_acc_reg  <= '0;
            held_amp_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                phase_step_reg <= cfg_wr_data;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (item.atom_start)
                        begin
                            held_amp_reg <= item.amplitude;
                            state_reg    <= ST_MUL_LO;
                        end
                        else
                        begin
                            phase_acc_reg <= phase_acc_reg + phase_step_reg;
                        end
                    end
                end
                ST_MUL_LO:
                begin
                    state_reg <= ST_MUL_HI;
                end
                ST_MUL_HI:
                begin
                    state_reg <= ST_ADD;
                end
                ST_ADD:
                begin
                    state_reg <= ST_PUSH;
                end
                ST_PUSH:
                begin
                    if (push)
                    begin
                        phase_acc_reg <= start_phase_reg + phase_step_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_reg  <= item.window_sample;
            len2_reg <= (L + 1)'(item.atom_length) + LEN_BIAS;
        end
        if (state_reg == ST_MUL_LO)
        begin
            prod_lo_reg <= phase_step_reg[H-1:0] * len2_reg;
        end
        if (state_reg == ST_MUL_HI)
        begin
            prod_hi_reg <= phase_step_reg[PHASE_BITS-1:H] * len2_reg;
        end
        if (state_reg == ST_ADD)
        begin
            start_phase_reg <= prod_sum[PW2-1:2] + QUARTER;
        end
    end

endmodule

// ===== rtl/core/wcas_queue.sv =====
// Small item queue that decouples the front end from the back end.
`timescale 1ns / 1ps

module wcas_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = wcas_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/core/wcas_back.sv =====
// Back end: cosine lookup, window and amplitude product, rounding and saturation.
`timescale 1ns / 1ps

module wcas_back #(
    parameter int PHASE_BITS      = wcas_pkg::PHASE_BITS_DEF,
    parameter int COS_TABLE_DEPTH = wcas_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  logic [PHASE_BITS-1:0]            pop_phase,
    input  logic [wcas_pkg::FRAC_BITS-1:0]   pop_window,
    input  logic [wcas_pkg::SAMPLE_BITS-1:0] pop_amplitude,
    output logic                             result_valid,
    input  logic                             result_ready,
    output wcas_pkg::out_item_t              result
);

    localparam int S         = wcas_pkg::FRAC_BITS;
    localparam int SB        = wcas_pkg::SAMPLE_BITS;
    localparam int ADDR_BITS = $clog2(COS_TABLE_DEPTH + 1) - 1;
    localparam int ROM_DEPTH = 1 << ADDR_BITS;
    localparam int MW        = SB + S + 1;
    localparam logic [MW-1:0] HALF_LSB = MW'(1) << (2 * S - 1);
    localparam logic [SB:0]   LIM_POS  = (SB + 1)'((1 << S) - 1);
    localparam logic [SB:0]   LIM_NEG  = (SB + 1)'(1 << S);

    typedef logic [S-1:0] rom_t [ROM_DEPTH];

    function automatic rom_t build_rom();
        rom_t rom;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            rom[i] = wcas_pkg::cos_entry(i, ADDR_BITS);
        end
        return rom;
    endfunction

    localparam rom_t COS_ROM = build_rom();

    logic                 adv;
    logic [1:0]           quad;
    logic [ADDR_BITS-1:0] idx;
    logic [ADDR_BITS-1:0] idx_eff;
    logic                 aneg;
    logic [SB-1:0]        amag;

    logic                 v1_reg;
    logic [S-1:0]         cmag_reg;
    logic [S+SB-1:0]      m1_reg;
    logic                 negx1_reg;

    logic                 v2_reg;
    logic [SB+S-1:0]      hp_reg;
    logic [2*S-1:0]       lp_reg;
    logic                 negx2_reg;

    logic                 out_valid_reg;
    wcas_pkg::out_item_t  out_reg;

    logic [MW-1:0]        t1;
    logic [MW-1:0]        t2;
    logic [SB:0]          mag;
    logic                 neg;
    logic [SB:0]          limit;
    logic                 clip;
    logic [SB:0]          sat;
    logic [SB-1:0]        res;

    assign adv          = !out_valid_reg || result_ready;
    assign pop_ready    = adv;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign quad    = pop_phase[PHASE_BITS-1 -: 2];
    assign idx     = pop_phase[PHASE_BITS-3 -: ADDR_BITS];
    assign idx_eff = quad[0] ? ~idx : idx;
    assign aneg    = pop_amplitude[SB-1];
    assign amag    = aneg ? (~pop_amplitude + SB'(1)) : pop_amplitude;

    assign t1    = MW'(lp_reg) + HALF_LSB;
    assign t2    = (t1 >> S) + MW'(hp_reg);
    assign mag   = t2[MW-1:S];
    assign neg   = negx2_reg && (mag != '0);
    assign limit = neg ? LIM_NEG : LIM_POS;
    assign clip  = (mag > limit);
    assign sat   = clip ? limit : mag;
    assign res   = neg ? SB'(~sat + (SB + 1)'(1)) : SB'(sat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= pop_valid;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cmag_reg      <= COS_ROM[idx_eff];
            m1_reg        <= pop_window * amag;
            negx1_reg     <= aneg ^ (quad[1] ^ quad[0]);
            hp_reg        <= m1_reg[S+SB-1:S] * cmag_reg;
            lp_reg        <= m1_reg[S-1:0] * cmag_reg;
            negx2_reg     <= negx1_reg;
            out_reg.sample  <= res;
            out_reg.clipped <= clip;
        end
    end

endmodule

// ===== rtl/core/windowed_cosine_atom_synth_unit.sv =====
// Top level of the windowed cosine atom synthesizer.
`timescale 1ns / 1ps

// Channels: item_valid/item_ready/item carry window sample, start mark, amplitude and
// length; result_valid/result_ready/result carry the Q1.15 sample and the clip flag.
// cfg_wr_en/cfg_wr_data write the phase step; write it only while the block is idle.
// One result per item, in order. A sample that continues an atom is taken back to back
// with the next while the queue has room; an item with atom_start set holds the front
// end while the start phase is formed from two half-width products and an add, and
// until that start sample is pushed into the queue.
// A four-item queue parts the front end from the three-stage back end (table read with
// window product, cosine products, round and saturate into the output register).
// When the receiver stalls the back end holds, the queue fills, then item_ready drops.
// Reset clears the phase step, phase, held amplitude, queue and pipeline; the cosine
// table is a constant ROM and needs no fill after reset.

module windowed_cosine_atom_synth_unit #(
    parameter int PHASE_BITS      = wcas_pkg::PHASE_BITS_DEF,
    parameter int COS_TABLE_DEPTH = wcas_pkg::COS_TABLE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [PHASE_BITS-1:0] cfg_wr_data,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  wcas_pkg::in_item_t    item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output wcas_pkg::out_item_t   result
);

    localparam int S  = wcas_pkg::FRAC_BITS;
    localparam int SB = wcas_pkg::SAMPLE_BITS;
    localparam int QW = PHASE_BITS + S + SB;

    logic                  q_push_valid;
    logic                  q_push_ready;
    logic [PHASE_BITS-1:0] q_push_phase;
    logic [S-1:0]          q_push_window;
    logic [SB-1:0]         q_push_amplitude;
    logic                  q_pop_valid;
    logic                  q_pop_ready;
    logic [QW-1:0]         q_pop_data;

    wcas_front #(
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .push_valid     (q_push_valid),
        .push_ready     (q_push_ready),
        .push_phase     (q_push_phase),
        .push_window    (q_push_window),
        .push_amplitude (q_push_amplitude)
    );

    wcas_queue #(
        .WIDTH (QW),
        .DEPTH (wcas_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_push_valid),
        .push_ready (q_push_ready),
        .push_data  ({q_push_phase, q_push_window, q_push_amplitude}),
        .pop_valid  (q_pop_valid),
        .pop_ready  (q_pop_ready),
        .pop_data   (q_pop_data)
    );

    wcas_back #(
        .PHASE_BITS      (PHASE_BITS),
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .pop_valid     (q_pop_valid),
        .pop_ready     (q_pop_ready),
        .pop_phase     (q_pop_data[QW-1 -: PHASE_BITS]),
        .pop_window    (q_pop_data[SB +: S]),
        .pop_amplitude (q_pop_data[SB-1:0]),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result)
    );

`ifndef SYNTHESIS
    a_start_holds_front: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.atom_start |=> !item_ready)
        else $error("front end took an item during start phase computation");

    a_start_no_direct_push: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.atom_start |-> !q_push_valid)
        else $error("start item pushed before its start phase was formed");

    a_start_push_timing: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.atom_start |-> ##4 q_push_valid)
        else $error("start item not offered to the queue after the multiply steps");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for the windowed cosine atom synthesizer: directed table, then random atoms.
`timescale 1ns / 1ps

module tb;

    localparam int ROM_BITS  = 10;
    localparam int ROM_DEPTH = 1 << ROM_BITS;
    localparam logic [63:0] TAYLOR [7] = '{
        64'd1073741824, 64'd1324675879, 64'd272375560, 64'd22401992,
        64'd987048, 64'd27060, 64'd506
    };

    typedef struct {
        bit                  load_step;
        logic [31:0]         step;
        wcas_pkg::in_item_t  stim;
        bit                  fixed;
        wcas_pkg::out_item_t want;
    } vector_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    logic [31:0]         cfg_wr_data;
    logic                item_valid;
    logic                item_ready;
    wcas_pkg::in_item_t  item;
    logic                result_valid;
    logic                result_ready;
    wcas_pkg::out_item_t result;

    logic [15:0]         cos_rom [ROM_DEPTH];
    logic [31:0]         step_reg;
    logic [31:0]         phase_acc;
    logic [15:0]         held_amp;
    wcas_pkg::out_item_t expected_samples [$];
    vector_t             directed [$];
    int                  error_count;
    int                  idle_pct;

    windowed_cosine_atom_synth_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic void build_cos_rom();
        logic [63:0] u;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] t;
        for (int i = 0; i < ROM_DEPTH; i++)
        begin
            u = 64'(2 * i + 1) << (29 - ROM_BITS);
            v = (u * u) >> 30;
            r = TAYLOR[6];
            for (int k = 5; k >= 0; k--)
            begin
                t = (r * v) >> 30;
                r = TAYLOR[k] - t;
                if (r[63])
                begin
                    r = '0;
                end
            end
            r = (r + (64'd1 << 14)) >> 15;
            cos_rom[i] = (r > 64'd32767) ? 16'd32767 : 16'(r);
        end
    endfunction

    function automatic wcas_pkg::out_item_t predict_sample(input wcas_pkg::in_item_t it);
        wcas_pkg::out_item_t res;
        logic [1:0]  quad;
        logic [9:0]  idx;
        logic        cneg;
        logic        aneg;
        logic        neg;
        logic        clip;
        logic [63:0] amag;
        logic [63:0] prod;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] mag;
        logic [63:0] limit;
        if (it.atom_start)
        begin
            held_amp  = it.amplitude;
            phase_acc = 32'((64'(step_reg) * (64'(it.atom_length) + 64'd2)) >> 2)
                        + 32'h4000_0000;
        end
        quad = phase_acc[31:30];
        idx  = phase_acc[29:20];
        if (quad[0])
        begin
            idx = ~idx;
        end
        cneg  = (quad == 2'd1) || (quad == 2'd2);
        aneg  = held_amp[15];
        amag  = aneg ? (64'd65536 - 64'(held_amp)) : 64'(held_amp);
        prod  = 64'(it.window_sample) * amag;
        hi    = prod >> 15;
        lo    = prod & 64'h7FFF;
        mag   = (hi * 64'(cos_rom[idx])
                 + ((lo * 64'(cos_rom[idx]) + (64'd1 << 29)) >> 15)) >> 15;
        neg   = (aneg != cneg) && (mag != 0);
        limit = neg ? 64'd32768 : 64'd32767;
        clip  = mag > limit;
        if (clip)
        begin
            mag = limit;
        end
        res.sample  = neg ? 16'(64'd65536 - mag) : 16'(mag);
        res.clipped = clip;
        phase_acc   = phase_acc + step_reg;
        return res;
    endfunction

    function automatic wcas_pkg::in_item_t rand_item(input bit start, input int len);
        wcas_pkg::in_item_t it;
        int                 pick;
        pick = $urandom_range(0, 15);
        it.window_sample = (pick == 0) ? '0 : (pick == 1) ? '1 : 15'($urandom);
        it.atom_start = start;
        pick = $urandom_range(0, 15);
        it.amplitude = (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh7FFF : 16'($urandom);
        it.atom_length = 16'(len);
        return it;
    endfunction

    function automatic void add_row(input bit load, input logic [31:0] step, input int win,
                                    input bit start, input int amp, input int len,
                                    input bit fixed, input int want);
        vector_t row;
        row.load_step    = load;
        row.step         = step;
        row.stim         = '{15'(win), start, 16'(amp), 16'(len)};
        row.fixed        = fixed;
        row.want.sample  = 16'(want);
        row.want.clipped = 1'b0;
        directed.push_back(row);
    endfunction

    task automatic report_mismatch(input string what);
        $display("ERROR %0t: %s", $time, what);
        error_count++;
    endtask

    task automatic send_item(input wcas_pkg::in_item_t it, input bit fixed,
                             input wcas_pkg::out_item_t want);
        wcas_pkg::out_item_t predicted;
        if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        predicted = predict_sample(it);
        expected_samples.push_back(fixed ? want : predicted);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_samples.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic write_step(input logic [31:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        step_reg = value;
    endtask

    initial
    begin
        result_ready <= 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            result_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        wcas_pkg::out_item_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                report_mismatch("result with no item outstanding");
            end
            else
            begin
                want = expected_samples.pop_front();
                if (result.sample !== want.sample)
                begin
                    report_mismatch($sformatf("sample got %0d expected %0d",
                                              result.sample, want.sample));
                end
                if (result.clipped !== want.clipped)
                begin
                    report_mismatch($sformatf("clipped got %0b expected %0b",
                                              result.clipped, want.clipped));
                end
            end
        end
    end

    initial
    begin
        wcas_pkg::out_item_t none;
        int          sent;
        int          len;
        int          tail;
        logic [31:0] step;
        none        = '0;
        error_count = 0;
        idle_pct    = 0;
        rst_n       <= 1'b0;
        item_valid  <= 1'b0;
        item        <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        build_cos_rom();
        step_reg  = '0;
        phase_acc = '0;
        held_amp  = '0;

        add_row(0, 0,              32767, 0, -32768, 65535, 1, 0);
        add_row(0, 0,              0,     1, 32767,  65535, 1, 0);
        add_row(0, 0,              32767, 0, 0,      0,     0, 0);
        add_row(0, 0,              32767, 1, -32768, 0,     0, 0);
        add_row(0, 0,              32767, 1, 0,      1,     1, 0);
        add_row(1, 32'h8000_0000,  32767, 1, 32767,  4,     0, 0);
        add_row(0, 0,              32767, 0, 0,      0,     0, 0);
        add_row(0, 0,              32767, 1, -32768, 4,     0, 0);
        add_row(0, 0,              32767, 0, -1,     65535, 0, 0);
        add_row(0, 0,              1,     1, -1,     65535, 0, 0);
        add_row(1, 32'hFFFF_FFFF,  32767, 1, 32767,  65535, 0, 0);
        add_row(0, 0,              21845, 0, 0,      0,     0, 0);
        add_row(0, 0,              10922, 0, 0,      0,     0, 0);
        add_row(0, 0,              16384, 1, -32768, 2,     0, 0);
        add_row(1, 32'h0123_4567,  32767, 1, 21845,  300,   0, 0);
        add_row(0, 0,              32767, 0, 0,      0,     0, 0);
        add_row(0, 0,              32767, 0, 0,      0,     0, 0);
        add_row(0, 0,              32767, 1, -21846, 7,     0, 0);
        add_row(0, 0,              24576, 0, 0,      0,     0, 0);
        add_row(0, 0,              32767, 1, 32767,  65534, 0, 0);
        add_row(1, 32'h4000_0000,  32767, 1, -32768, 2,     0, 0);
        add_row(0, 0,              32767, 0, 0,      0,     0, 0);
        add_row(0, 0,              32767, 0, 0,      0,     0, 0);
        add_row(0, 0,              32767, 0, 0,      0,     0, 0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 15;
        foreach (directed[i])
        begin
            if (directed[i].load_step)
            begin
                write_step(directed[i].step);
            end
            send_item(directed[i].stim, directed[i].fixed, directed[i].want);
        end

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: step = '0;
                1: step = 32'h8000_0000;
                2: step = 32'd1;
                3: step = $urandom_range(0, 32'h00FF_FFFF);
                default: step = $urandom;
            endcase
            write_step(step);
            idle_pct = (ph == 2 || ph == 7) ? 0 : $urandom_range(5, 30);
            sent = 0;
            while (sent < 200)
            begin
                if (ph == 4 && sent >= 100 && sent < 110)
                begin
                    wait_idle();
                    sent = 110;
                end
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(1, 48);
                send_item(rand_item(1'b1, len), 1'b0, none);
                sent++;
                tail = (len > 48) ? $urandom_range(0, 48) : len - 1;
                if ($urandom_range(0, 9) == 0 && tail > 0)
                begin
                    tail = $urandom_range(0, tail);
                end
                for (int n = 0; n < tail; n++)
                begin
                    send_item(rand_item(1'b0, $urandom), 1'b0, none);
                    sent++;
                end
                if ($urandom_range(0, 7) == 0)
                begin
                    send_item(rand_item(1'($urandom), $urandom), 1'b0, none);
                    sent++;
                end
            end
        end

        wait_idle();
        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
